// ===== sv/btcs_pkg.sv =====
// ----------------------------------------------------------------------------
// btcs_pkg
// Types, codes and the sequencer program of the block transfer command
// splitter.
// ----------------------------------------------------------------------------
package btcs_pkg;

   // most commands one request may produce
   localparam int unsigned MAX_CHUNKS = 64;
   localparam int unsigned MANY_W = 32 + $clog2(MAX_CHUNKS + 1);

   // highest start address that still fits the six-byte form
   localparam logic [31:0] SHORT_LIMIT = 32'h001F_FFFF;

   // configuration register indexes
   localparam logic [1:0] REG_BLOCK_LENGTH = 2'd0;
   localparam logic [1:0] REG_MAX_XFER     = 2'd1;
   localparam logic [1:0] REG_LUN          = 2'd2;

   // reset values of the configuration registers
   localparam logic [16:0] BLOCK_LENGTH_RST = 17'd2048;
   localparam logic [31:0] MAX_XFER_RST     = 32'd65536;
   localparam logic [2:0]  LUN_RST          = 3'd0;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TOO_MANY  = 2'd1;
   localparam logic [1:0] STATUS_ZERO_SIZE = 2'd2;

   // command opcodes
   localparam logic [7:0] OP_READ6   = 8'h08;
   localparam logic [7:0] OP_WRITE6  = 8'h0A;
   localparam logic [7:0] OP_READ10  = 8'h28;
   localparam logic [7:0] OP_WRITE10 = 8'h2A;

   // request item
   typedef struct packed {
      logic        func;
      logic [31:0] start_block;
      logic [15:0] block_count;
   } req_type;

   // result item
   typedef struct packed {
      logic [1:0]  status;
      logic        long_form;
      logic [7:0]  opcode;
      logic [7:0]  unit_byte;
      logic [31:0] command_address;
      logic [15:0] command_blocks;
      logic [31:0] byte_count;
      logic        last;
   } rsp_type;

   // sequencer program counter
   localparam int unsigned STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_WAIT     = 3'd0;
   localparam step_type STEP_INIT     = 3'd1;
   localparam step_type STEP_DIV      = 3'd2;
   localparam step_type STEP_CHK_ZERO = 3'd3;
   localparam step_type STEP_CHK_MANY = 3'd4;
   localparam step_type STEP_EMIT     = 3'd5;
   localparam step_type STEP_ERR_ZERO = 3'd6;
   localparam step_type STEP_ERR_MANY = 3'd7;

   // datapath operation of one step
   typedef enum logic [2:0] {
      UOP_WAIT,
      UOP_INIT,
      UOP_DIV,
      UOP_CHECK,
      UOP_EMIT,
      UOP_ERR_ZERO,
      UOP_ERR_MANY
   } uop_type;

   // branch condition of one step
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_START,
      COND_DIV_MORE,
      COND_ZERO,
      COND_MANY,
      COND_MORE
   } cond_type;

   // one control word
   typedef struct packed {
      uop_type  uop;
      cond_type cond;
      step_type jmp_true;
      step_type jmp_false;
   } ctrl_type;

   // program store
   function automatic ctrl_type ucode_rom(input step_type pc);
      ctrl_type cw;
      case (pc)
         STEP_WAIT:     cw = '{UOP_WAIT,     COND_START,    STEP_INIT,     STEP_WAIT};
         STEP_INIT:     cw = '{UOP_INIT,     COND_ALWAYS,   STEP_DIV,      STEP_DIV};
         STEP_DIV:      cw = '{UOP_DIV,      COND_DIV_MORE, STEP_DIV,      STEP_CHK_ZERO};
         STEP_CHK_ZERO: cw = '{UOP_CHECK,    COND_ZERO,     STEP_ERR_ZERO, STEP_CHK_MANY};
         STEP_CHK_MANY: cw = '{UOP_CHECK,    COND_MANY,     STEP_ERR_MANY, STEP_EMIT};
         STEP_EMIT:     cw = '{UOP_EMIT,     COND_MORE,     STEP_EMIT,     STEP_WAIT};
         STEP_ERR_ZERO: cw = '{UOP_ERR_ZERO, COND_ALWAYS,   STEP_WAIT,     STEP_WAIT};
         STEP_ERR_MANY: cw = '{UOP_ERR_MANY, COND_ALWAYS,   STEP_WAIT,     STEP_WAIT};
         default:       cw = '{UOP_WAIT,     COND_ALWAYS,   STEP_WAIT,     STEP_WAIT};
      endcase
      return cw;
   endfunction

endpackage

// ===== sv/block_transfer_command_splitter.sv =====
// A request is accepted when start is high and busy is low; the sequencer then runs a setup
// step, 32 divide steps of the chunk-size divider, two check steps and the issue step (a zero
// chunk size skips the second check for an error step); then one result per cycle per chunk.
// The block takes no new request until it is through with the last one: busy stays high
// until the last result is issued. The receiver cannot stall.
// Reset (synchronous): sequencer idle, registers at 2048 / 65536 / 0.
// ----------------------------------------------------------------------------
// block_transfer_command_splitter
// Splits a block read or write request into six- or ten-byte command items,
// under control of a small microcoded sequencer with an APB register port.
// ----------------------------------------------------------------------------
module block_transfer_command_splitter (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   output logic              busy,
   input  btcs_pkg::req_type req_item,
   // result channel
   output logic              rsp_valid,
   output btcs_pkg::rsp_type rsp_item,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // configuration registers
   logic [16:0] block_length_ff;
   logic [31:0] max_xfer_ff;
   logic [2:0]  lun_ff;
   logic        cfg_wr;
   logic [1:0]  cfg_idx;

   // sequencer
   btcs_pkg::step_type pc_ff, pc_in;
   btcs_pkg::ctrl_type cw;
   logic               cond_hit;

   // datapath registers
   logic        func_ff, func_in;
   logic        long_ff, long_in;
   logic [31:0] adr_ff, adr_in;
   logic [15:0] count_ff, count_in;
   logic [16:0] rem_ff, rem_in;
   logic [31:0] quot_ff, quot_in;
   logic [4:0]  iter_ff, iter_in;
   logic        rsp_valid_ff, rsp_valid_in;
   btcs_pkg::rsp_type rsp_ff, rsp_in;

   // datapath helpers
   logic [17:0] trial;
   logic [17:0] diff;
   logic        more;
   logic        many;
   logic [15:0] blocks;
   logic [32:0] bytes_full;
   logic [btcs_pkg::MANY_W-1:0] limit;

   // register port
   assign pready  = 1'b1;
   assign cfg_idx = paddr[3:2];
   assign cfg_wr  = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_length_ff <= btcs_pkg::BLOCK_LENGTH_RST;
         max_xfer_ff     <= btcs_pkg::MAX_XFER_RST;
         lun_ff          <= btcs_pkg::LUN_RST;
      end else if (cfg_wr) begin
         case (cfg_idx)
            btcs_pkg::REG_BLOCK_LENGTH: block_length_ff <= pwdata[16:0];
            btcs_pkg::REG_MAX_XFER:     max_xfer_ff     <= pwdata;
            btcs_pkg::REG_LUN:          lun_ff          <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   // register read
   always_comb begin
      case (cfg_idx)
         btcs_pkg::REG_BLOCK_LENGTH: prdata = {15'd0, block_length_ff};
         btcs_pkg::REG_MAX_XFER:     prdata = max_xfer_ff;
         btcs_pkg::REG_LUN:          prdata = {29'd0, lun_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   // control word fetch and busy
   assign cw   = btcs_pkg::ucode_rom(pc_ff);
   assign busy = (pc_ff != btcs_pkg::STEP_WAIT);

   // one restoring divide step
   assign trial = {rem_ff, quot_ff[31]};
   assign diff  = trial - {1'b0, block_length_ff};

   // chunk checks, the quotient register holds the chunk size after the divide
   assign limit = btcs_pkg::MANY_W'(quot_ff) * btcs_pkg::MANY_W'(btcs_pkg::MAX_CHUNKS);
   assign many  = btcs_pkg::MANY_W'(count_ff) > limit;
   assign more  = {16'd0, count_ff} > quot_ff;

   // blocks in the chunk being issued and its byte count
   assign blocks     = more ? quot_ff[15:0] : count_ff;
   assign bytes_full = {17'd0, blocks} * {16'd0, block_length_ff};

   // branch condition select
   always_comb begin
      case (cw.cond)
         btcs_pkg::COND_ALWAYS:   cond_hit = 1'b1;
         btcs_pkg::COND_START:    cond_hit = start;
         btcs_pkg::COND_DIV_MORE: cond_hit = (iter_ff != 5'd0);
         btcs_pkg::COND_ZERO:     cond_hit = (block_length_ff == 17'd0) || (quot_ff == 32'd0);
         btcs_pkg::COND_MANY:     cond_hit = many;
         btcs_pkg::COND_MORE:     cond_hit = more;
         default:                 cond_hit = 1'b1;
      endcase
      pc_in = cond_hit ? cw.jmp_true : cw.jmp_false;
   end

   // datapath operations
   always_comb begin
      func_in      = func_ff;
      long_in      = long_ff;
      adr_in       = adr_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      iter_in      = iter_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (cw.uop)
         btcs_pkg::UOP_WAIT: begin
            // latch the request item
            if (start) begin
               func_in  = req_item.func;
               adr_in   = req_item.start_block;
               count_in = req_item.block_count;
               long_in  = req_item.start_block > btcs_pkg::SHORT_LIMIT;
            end
         end
         btcs_pkg::UOP_INIT: begin
            rem_in  = 17'd0;
            quot_in = max_xfer_ff;
            iter_in = 5'd31;
         end
         btcs_pkg::UOP_DIV: begin
            if (!diff[17]) begin
               rem_in = diff[16:0];
            end else begin
               rem_in = trial[16:0];
            end
            quot_in = {quot_ff[30:0], ~diff[17]};
            iter_in = iter_ff - 5'd1;
         end
         btcs_pkg::UOP_CHECK: ;
         btcs_pkg::UOP_EMIT: begin
            // build one command item and advance to the next chunk
            rsp_valid_in       = 1'b1;
            rsp_in.status      = btcs_pkg::STATUS_OK;
            rsp_in.long_form   = long_ff;
            rsp_in.byte_count  = bytes_full[31:0];
            rsp_in.last        = ~more;
            if (long_ff) begin
               rsp_in.opcode          = func_ff ? btcs_pkg::OP_WRITE10 : btcs_pkg::OP_READ10;
               rsp_in.unit_byte       = {lun_ff, 5'd0};
               rsp_in.command_address = adr_ff;
               rsp_in.command_blocks  = blocks;
            end else begin
               rsp_in.opcode          = func_ff ? btcs_pkg::OP_WRITE6 : btcs_pkg::OP_READ6;
               rsp_in.unit_byte       = {lun_ff, adr_ff[20:16]};
               rsp_in.command_address = {16'd0, adr_ff[15:0]};
               rsp_in.command_blocks  = {8'd0, blocks[7:0]};
            end
            if (more) begin
               adr_in   = adr_ff + quot_ff;
               count_in = count_ff - quot_ff[15:0];
            end
         end
         btcs_pkg::UOP_ERR_ZERO: begin
            rsp_valid_in  = 1'b1;
            rsp_in        = '0;
            rsp_in.status = btcs_pkg::STATUS_ZERO_SIZE;
            rsp_in.last   = 1'b1;
         end
         btcs_pkg::UOP_ERR_MANY: begin
            rsp_valid_in  = 1'b1;
            rsp_in        = '0;
            rsp_in.status = btcs_pkg::STATUS_TOO_MANY;
            rsp_in.last   = 1'b1;
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= btcs_pkg::STEP_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      func_in_ff_update: begin
         func_ff  <= func_in;
         long_ff  <= long_in;
         adr_ff   <= adr_in;
         count_ff <= count_in;
         rem_ff   <= rem_in;
         quot_ff  <= quot_in;
         iter_ff  <= iter_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTH
   // an accepted request holds the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // commands of one request come in consecutive cycles
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.last) |=> rsp_valid)
      else $error("gap inside a command sequence");

   // an error result is always alone and last
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != btcs_pkg::STATUS_OK)) |-> rsp_item.last)
      else $error("error result not marked last");

   // nothing follows the last item of a request in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last) |=> !rsp_valid)
      else $error("result after last item");
`endif

endmodule

// ===== tb/tb_block_transfer_command_splitter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_transfer_command_splitter
// Self-checking bench for the block transfer command splitter. A scoreboard
// splits each accepted request into the expected command items and checks
// every result item against them field by field. Register settings cycle
// through the reset values, the extremes, the zero-size cases and random ones.
// ----------------------------------------------------------------------------
module tb_block_transfer_command_splitter;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

   // expected command store and splitter prediction
   class cmd_scoreboard;
      logic [16:0]       block_len;
      logic [31:0]       max_xfer;
      logic [2:0]        lun;
      btcs_pkg::rsp_type expected_cmds [$];
      int unsigned       mismatches;
      int unsigned       commands_checked;

      function new();
         block_len        = btcs_pkg::BLOCK_LENGTH_RST;
         max_xfer         = btcs_pkg::MAX_XFER_RST;
         lun              = btcs_pkg::LUN_RST;
         mismatches       = 0;
         commands_checked = 0;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("mismatch: %s", what);
      endtask

      function void set_register(logic [1:0] idx, logic [31:0] val);
         case (idx)
            btcs_pkg::REG_BLOCK_LENGTH: block_len = val[16:0];
            btcs_pkg::REG_MAX_XFER:     max_xfer  = val;
            btcs_pkg::REG_LUN:          lun       = val[2:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] register_value(logic [1:0] idx);
         logic [31:0] v;
         case (idx)
            btcs_pkg::REG_BLOCK_LENGTH: v = {15'd0, block_len};
            btcs_pkg::REG_MAX_XFER:     v = max_xfer;
            btcs_pkg::REG_LUN:          v = {29'd0, lun};
            default:                    v = '0;
         endcase
         return v;
      endfunction

      function logic [63:0] chunk_blocks();
         logic [63:0] num;
         logic [63:0] den;
         num = {32'd0, max_xfer};
         den = {47'd0, block_len};
         if (den == 0) return 64'd0;
         return num / den;
      endfunction

      function int unsigned pending();
         return expected_cmds.size();
      endfunction

      // one command item of a chunk
      function btcs_pkg::rsp_type make_cmd(logic lf, logic wr, logic [31:0] addr,
                                           logic [15:0] blocks, logic last);
         btcs_pkg::rsp_type c;
         logic [63:0]       nblk;
         logic [63:0]       blen;
         logic [63:0]       prod;
         nblk = {48'd0, blocks};
         blen = {47'd0, block_len};
         prod = nblk * blen;
         c = '0;
         c.status     = btcs_pkg::STATUS_OK;
         c.long_form  = lf;
         c.byte_count = prod[31:0];
         c.last       = last;
         if (lf) begin
            c.opcode          = wr ? btcs_pkg::OP_WRITE10 : btcs_pkg::OP_READ10;
            c.unit_byte       = {lun, 5'd0};
            c.command_address = addr;
            c.command_blocks  = blocks;
         end else begin
            c.opcode          = wr ? btcs_pkg::OP_WRITE6 : btcs_pkg::OP_READ6;
            c.unit_byte       = {lun, addr[20:16]};
            c.command_address = {16'd0, addr[15:0]};
            c.command_blocks  = {8'd0, blocks[7:0]};
         end
         return c;
      endfunction

      function btcs_pkg::rsp_type make_error(logic [1:0] code);
         btcs_pkg::rsp_type e;
         e = '0;
         e.status = code;
         e.last   = 1'b1;
         return e;
      endfunction

      // split one accepted request into its expected commands
      function void note_request(btcs_pkg::req_type r);
         logic [63:0] chunk;
         logic [63:0] remaining;
         logic [63:0] ncmd;
         logic [31:0] addr;
         logic        lf;
         chunk     = chunk_blocks();
         remaining = {48'd0, r.block_count};
         if (chunk == 0) begin
            expected_cmds.push_back(make_error(btcs_pkg::STATUS_ZERO_SIZE));
            return;
         end
         ncmd = (remaining <= chunk) ? 64'd1 : (remaining + chunk - 64'd1) / chunk;
         if (ncmd > btcs_pkg::MAX_CHUNKS) begin
            expected_cmds.push_back(make_error(btcs_pkg::STATUS_TOO_MANY));
            return;
         end
         lf   = r.start_block > btcs_pkg::SHORT_LIMIT;
         addr = r.start_block;
         while (remaining > chunk) begin
            expected_cmds.push_back(make_cmd(lf, r.func, addr, chunk[15:0], 1'b0));
            addr      = addr + chunk[31:0];
            remaining = remaining - chunk;
         end
         expected_cmds.push_back(make_cmd(lf, r.func, addr, remaining[15:0], 1'b1));
      endfunction

      task cmp_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("command %0d %s got %h want %h",
                                      commands_checked, name, got, want));
      endtask

      // compare one result item with the oldest expectation
      task check_command(btcs_pkg::rsp_type got);
         btcs_pkg::rsp_type want;
         if (expected_cmds.size() == 0) begin
            report_mismatch($sformatf("command %0d arrived with none expected: %h",
                                      commands_checked, got));
         end else begin
            want = expected_cmds.pop_front();
            cmp_field("status", {30'd0, got.status}, {30'd0, want.status});
            cmp_field("long_form", {31'd0, got.long_form}, {31'd0, want.long_form});
            cmp_field("opcode", {24'd0, got.opcode}, {24'd0, want.opcode});
            cmp_field("unit_byte", {24'd0, got.unit_byte}, {24'd0, want.unit_byte});
            cmp_field("command_address", got.command_address, want.command_address);
            cmp_field("command_blocks", {16'd0, got.command_blocks},
                      {16'd0, want.command_blocks});
            cmp_field("byte_count", got.byte_count, want.byte_count);
            cmp_field("last", {31'd0, got.last}, {31'd0, want.last});
         end
         commands_checked++;
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   btcs_pkg::req_type req_item = '0;
   logic              rsp_valid;
   btcs_pkg::rsp_type rsp_item;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [3:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   cmd_scoreboard sb = new();
   int unsigned   cycles = 0;
   int unsigned   requests_sent = 0;
   int unsigned   settings_used = 0;

   block_transfer_command_splitter dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_command(rsp_item);
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_block_transfer_command_splitter: errors");
         $finish;
      end
   end

   // register write, then read back
   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(idx, val);
      settings_used++;
      // read phase
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== sb.register_value(idx))
         sb.report_mismatch($sformatf("register %0d read %h want %h",
                                      idx, prdata, sb.register_value(idx)));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // present one item and hold it until accepted
   task automatic send_request(btcs_pkg::req_type r);
      req_item <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      requests_sent++;
   endtask

   task automatic idle_cycles(int unsigned n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // wait until every expected command is in and the block is idle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // random request shaped around the current chunk size
   function automatic btcs_pkg::req_type random_request();
      btcs_pkg::req_type r;
      logic [63:0]       chunk;
      logic [63:0]       lim;
      logic [63:0]       pick;
      int unsigned       sel;
      chunk = sb.chunk_blocks();
      lim   = (chunk == 0 || chunk * btcs_pkg::MAX_CHUNKS > 65535)
              ? 64'd65535 : chunk * btcs_pkg::MAX_CHUNKS;
      r.func = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         r.block_count = 16'd0;
      end else if (sel < 14) begin
         r.block_count = 16'hFFFF;
      end else if (sel < 24) begin
         // counts on the chunk boundaries
         case ($urandom_range(0, 4))
            0: pick = chunk;
            1: pick = chunk + 1;
            2: pick = chunk * btcs_pkg::MAX_CHUNKS;
            3: pick = chunk * btcs_pkg::MAX_CHUNKS + 1;
            default: pick = chunk * btcs_pkg::MAX_CHUNKS - 1;
         endcase
         r.block_count = (pick > 65535) ? 16'hFFFF : pick[15:0];
      end else if (sel < 90) begin
         r.block_count = 16'($urandom_range(1, lim[31:0]));
      end else begin
         r.block_count = 16'($urandom_range(0, 65535));
      end
      sel = $urandom_range(0, 99);
      if (sel < 35)
         r.start_block = $urandom_range(0, btcs_pkg::SHORT_LIMIT);
      else if (sel < 47)
         r.start_block = btcs_pkg::SHORT_LIMIT - $urandom_range(0, 16'hFFFF);
      else if (sel < 54)
         r.start_block = ALL_ONES - $urandom_range(0, 16'hFFFF);
      else if (sel < 60)
         case ($urandom_range(0, 3))
            0: r.start_block = 32'd0;
            1: r.start_block = ALL_ONES;
            2: r.start_block = btcs_pkg::SHORT_LIMIT;
            default: r.start_block = btcs_pkg::SHORT_LIMIT + 1;
         endcase
      else
         r.start_block = $urandom;
      return r;
   endfunction

   // stimulus
   initial begin
      btcs_pkg::req_type directed_reqs [$];
      logic [31:0]       bl_val;
      logic [31:0]       mx_val;
      logic [31:0]       lun_val;
      logic [63:0]       mx_wide;
      int unsigned       n_items;
      int unsigned       gap;
      bit                steady;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: chunk of 32 blocks
      directed_reqs.push_back('{1'b0, 32'h0000_0000, 16'd0});
      directed_reqs.push_back('{1'b1, 32'h0000_0000, 16'd1});
      directed_reqs.push_back('{1'b0, 32'h001F_FFFF, 16'd32});
      directed_reqs.push_back('{1'b1, 32'h0020_0000, 16'd33});
      directed_reqs.push_back('{1'b0, 32'h001F_FFF0, 16'd100});
      directed_reqs.push_back('{1'b1, 32'h0001_FFF0, 16'd70});
      directed_reqs.push_back('{1'b1, 32'hFFFF_FFF0, 16'd64});
      directed_reqs.push_back('{1'b0, 32'hFFFF_FFFF, 16'd2048});
      directed_reqs.push_back('{1'b1, 32'h0000_0000, 16'd2049});
      directed_reqs.push_back('{1'b0, 32'h0000_0000, 16'hFFFF});
      directed_reqs.push_back('{1'b1, 32'hAAAA_AAAA, 16'h5555});
      directed_reqs.push_back('{1'b0, 32'h5555_5555, 16'd2047});
      foreach (directed_reqs[i]) send_request(directed_reqs[i]);

      for (int unsigned phase = 0; phase < 10; phase++) begin
         n_items = 62;
         steady  = 1'b0;
         lun_val = $urandom_range(0, 7);
         case (phase)
            0: n_items = 40;
            1: begin
               bl_val = 32'd1; mx_val = 32'd1; lun_val = 32'd7;
            end
            2: begin
               bl_val = 32'h1_0000; mx_val = ALL_ONES; lun_val = 32'd5;
            end
            3: begin
               bl_val = 32'd512; mx_val = 32'h1_0000; lun_val = 32'd3;
               steady = 1'b1;
            end
            4: begin
               // block larger than the transfer limit
               bl_val = 32'h1_0000; mx_val = 32'hFFFF; n_items = 10;
            end
            5: begin
               bl_val = 32'd0; mx_val = 32'd4096; n_items = 10;
            end
            6: begin
               bl_val = 32'd1; mx_val = 32'd0; n_items = 10;
            end
            default: begin
               bl_val  = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4096)
                                                     : $urandom_range(1, 32'h1_0000);
               mx_wide = {32'd0, bl_val} * $urandom_range(1, 1500)
                         + $urandom_range(0, bl_val - 1);
               mx_val  = (mx_wide > ALL_ONES) ? ALL_ONES : mx_wide[31:0];
            end
         endcase

         // settings change only with the block idle
         if (phase != 0) begin
            drain();
            csr_write(btcs_pkg::REG_BLOCK_LENGTH, bl_val);
            csr_write(btcs_pkg::REG_MAX_XFER, mx_val);
            csr_write(btcs_pkg::REG_LUN, lun_val);
         end

         for (int unsigned k = 0; k < n_items; k++) begin
            if (!steady && $urandom_range(0, 99) < 9) begin
               gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 120)
                                                 : $urandom_range(1, 4);
               idle_cycles(gap);
            end
            send_request(random_request());
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d commands never arrived", sb.pending()));

      $display("sent %0d requests under %0d register writes, checked %0d commands",
               requests_sent, settings_used, sb.commands_checked);
      $display("covered short and long forms, chunk splits, zero-size and overflow errors");
      if (sb.mismatches == 0)
         $display("tb_block_transfer_command_splitter: clean");
      else
         $display("tb_block_transfer_command_splitter: errors");
      $finish;
   end

endmodule
